FILE: src/mssb_pkg.sv
// shared types and constants for the multi stack shared buffer unit
// no dependencies; used by the top module, the checker and the testbench
package mssb_pkg;

    localparam int NUM_STACKS  = 4;
    localparam int STORE_DEPTH = 64;

    localparam int SEL_W  = 2;
    localparam int DATA_W = 32;
    localparam int STS_W  = 2;
    localparam int IDX_W  = $clog2(STORE_DEPTH);
    // one extra bit so that STORE_DEPTH itself can stand for null
    localparam int LINK_W = IDX_W + 1;
    localparam int WORD_W = LINK_W + DATA_W;

    localparam logic [LINK_W-1:0] NIL = LINK_W'(STORE_DEPTH);

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    localparam logic [STS_W-1:0] STS_DONE  = 2'd0;
    localparam logic [STS_W-1:0] STS_FULL  = 2'd1;
    localparam logic [STS_W-1:0] STS_EMPTY = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic                     mode;
        logic [SEL_W-1:0]         stack_sel;
        logic signed [DATA_W-1:0] push_value;
    } t_in_word;

    typedef struct packed {
        logic [STS_W-1:0]         status;
        logic signed [DATA_W-1:0] pop_value;
    } t_out_word;

endpackage

FILE: src/mssb_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
module mssb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/multi_stack_shared_buffer_unit.sv
// Several LIFO stacks that share one store of linked entries.
// Input channel (i_in_valid / o_in_stall / i_in_data): one word per push or
// pop, addressed to a stack by stack_sel. Output channel (o_out_valid /
// i_out_stall / o_out_data): one word per input word, in order, carrying a
// status and, for a successful pop, the popped value.
// A result enters the output register with the write back of its word.
// Words are handled one at a time; the accept cycle reads the entry and
// its link from the store, the execute state then writes the store back and the
// stack pointers, and a new word is only taken after that write back.
// While a result waits under i_out_stall the next input word is still
// taken and read; its write back waits until the output register frees.
// Entries are handed out first from a free list of returned ones, then
// from a count of never used entries, so the store needs no clearing.
// Reset (i_rst_n low at a clock edge) empties every stack, frees every
// entry and drops any pending result; input is taken from the next cycle.
// Depends on mssb_pkg and mssb_ram.
module multi_stack_shared_buffer_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mssb_pkg::t_in_word i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mssb_pkg::t_out_word o_out_data
);

    mssb_pkg::t_state r_state, n_state;

    logic [mssb_pkg::LINK_W-1:0] r_top [mssb_pkg::NUM_STACKS];
    logic [mssb_pkg::LINK_W-1:0] r_free_head, n_free_head;
    logic [mssb_pkg::LINK_W-1:0] r_fresh, n_fresh;

    // item latched at accept
    logic                        r_mode;
    logic [mssb_pkg::SEL_W-1:0]  r_sel;
    logic [mssb_pkg::DATA_W-1:0] r_val;
    logic [mssb_pkg::IDX_W-1:0]  r_idx;
    logic                        r_recycled;
    logic [mssb_pkg::STS_W-1:0]  r_status;

    logic                r_out_valid;
    mssb_pkg::t_out_word r_out_data;

    logic                        in_acc;
    logic                        sel_ok;
    logic [mssb_pkg::LINK_W-1:0] top_sel;
    logic                        have_recycled;
    logic                        have_fresh;
    logic [mssb_pkg::LINK_W-1:0] acc_idx;
    logic [mssb_pkg::STS_W-1:0]  acc_status;

    logic                        out_free;
    logic                        exec_go;
    logic                        ok;
    logic                        mem_we;
    logic [mssb_pkg::WORD_W-1:0] mem_wdata;
    logic [mssb_pkg::WORD_W-1:0] mem_rdata;
    logic [mssb_pkg::LINK_W-1:0] rd_link;
    logic [mssb_pkg::LINK_W-1:0] rd_link_cl;
    logic                        top_we;
    logic [mssb_pkg::LINK_W-1:0] top_wval;
    logic [mssb_pkg::DATA_W-1:0] pop_bits;

    assign o_in_stall = (r_state != mssb_pkg::ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;

    // decisions and read address at accept time
    always_comb begin
        sel_ok        = (int'(i_in_data.stack_sel) < mssb_pkg::NUM_STACKS);
        top_sel       = sel_ok ? r_top[i_in_data.stack_sel] : mssb_pkg::NIL;
        have_recycled = (r_free_head < mssb_pkg::NIL);
        have_fresh    = (r_fresh < mssb_pkg::NIL);
        if (i_in_data.mode == mssb_pkg::MODE_PUSH) begin
            acc_idx    = have_recycled ? r_free_head : r_fresh;
            acc_status = (sel_ok && (have_recycled || have_fresh)) ?
                         mssb_pkg::STS_DONE : mssb_pkg::STS_FULL;
        end else begin
            acc_idx    = top_sel;
            acc_status = (top_sel < mssb_pkg::NIL) ?
                         mssb_pkg::STS_DONE : mssb_pkg::STS_EMPTY;
        end
    end

    mssb_ram #(
        .WIDTH (mssb_pkg::WORD_W),
        .DEPTH (mssb_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_idx),
        .i_wdata (mem_wdata),
        .i_re    (in_acc),
        .i_raddr (acc_idx[mssb_pkg::IDX_W-1:0]),
        .o_rdata (mem_rdata)
    );

    assign rd_link    = mem_rdata[mssb_pkg::WORD_W-1:mssb_pkg::DATA_W];
    assign rd_link_cl = (rd_link < mssb_pkg::NIL) ? rd_link : mssb_pkg::NIL;
    assign out_free   = !r_out_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mssb_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = mssb_pkg::ST_EXEC;
                end
            end
            mssb_pkg::ST_EXEC: begin
                if (out_free) begin
                    n_state = mssb_pkg::ST_IDLE;
                end
            end
            default: n_state = mssb_pkg::ST_IDLE;
        endcase
    end

    // write back and pointer updates
    always_comb begin
        exec_go     = (r_state == mssb_pkg::ST_EXEC) && out_free;
        ok          = (r_status == mssb_pkg::STS_DONE);
        mem_we      = 1'b0;
        mem_wdata   = mem_rdata;
        top_we      = 1'b0;
        top_wval    = rd_link_cl;
        n_free_head = r_free_head;
        n_fresh     = r_fresh;
        pop_bits    = '0;
        if (exec_go && ok) begin
            mem_we = 1'b1;
            top_we = 1'b1;
            if (r_mode == mssb_pkg::MODE_PUSH) begin
                mem_wdata = {r_top[r_sel], r_val};
                top_wval  = {1'b0, r_idx};
                if (r_recycled) begin
                    n_free_head = rd_link_cl;
                end else begin
                    n_fresh = r_fresh + 1'b1;
                end
            end else begin
                // freed entry goes to the head of the free list
                mem_wdata   = {r_free_head, mem_rdata[mssb_pkg::DATA_W-1:0]};
                top_wval    = rd_link_cl;
                n_free_head = {1'b0, r_idx};
                pop_bits    = mem_rdata[mssb_pkg::DATA_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mssb_pkg::ST_IDLE;
            r_free_head <= mssb_pkg::NIL;
            r_fresh     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < mssb_pkg::NUM_STACKS; i++) begin
                r_top[i] <= mssb_pkg::NIL;
            end
        end else begin
            r_state     <= n_state;
            r_free_head <= n_free_head;
            r_fresh     <= n_fresh;
            if (top_we) begin
                r_top[r_sel] <= top_wval;
            end
            if (exec_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode     <= i_in_data.mode;
            r_sel      <= i_in_data.stack_sel;
            r_val      <= i_in_data.push_value;
            r_idx      <= acc_idx[mssb_pkg::IDX_W-1:0];
            r_recycled <= have_recycled;
            r_status   <= acc_status;
        end
        if (exec_go) begin
            r_out_data.status    <= r_status;
            r_out_data.pop_value <= $signed(pop_bits);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef ASSERT_OFF
    // a recycled entry was always handed out from the fresh count before
    a_free_below_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free_head < mssb_pkg::NIL) |-> (r_free_head < r_fresh))
        else $error("free list head points at a never used entry");

    a_fresh_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh <= mssb_pkg::NIL)
        else $error("fresh entry count beyond store depth");

    // the execute cycle only follows an accept or a held execute cycle
    a_exec_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mssb_pkg::ST_EXEC) |->
        $past(in_acc || (r_state == mssb_pkg::ST_EXEC)))
        else $error("execute cycle without an accepted word");

    // a refused word never touches the store
    a_refused_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mssb_pkg::ST_EXEC && r_status != mssb_pkg::STS_DONE) |-> !mem_we)
        else $error("store written for a refused word");
`endif

endmodule

FILE: tb/mssb_checker.sv
// checker for the multi stack shared buffer unit: watches both channels,
// predicts every result word and compares it field by field
// depends on mssb_pkg
module mssb_checker
    import mssb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_word  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_word i_out_data,
    output int        o_error_count,
    output int        o_pending_count
);

    logic signed [DATA_W-1:0] entry_word [STORE_DEPTH];
    logic [LINK_W-1:0]        entry_next [STORE_DEPTH];
    logic [LINK_W-1:0]        stack_top  [NUM_STACKS];
    logic [LINK_W-1:0]        free_first;

    t_out_word pending_results[$];
    int        mismatch_total = 0;
    int        pending_total  = 0;

    assign o_error_count   = mismatch_total;
    assign o_pending_count = pending_total;

    function automatic void clear_stacks();
        for (int i = 0; i < STORE_DEPTH; i++) begin
            entry_word[i] = '0;
            entry_next[i] = LINK_W'(i + 1);
        end
        for (int i = 0; i < NUM_STACKS; i++) begin
            stack_top[i] = NIL;
        end
        free_first = '0;
    endfunction

    // applies one push or pop to the shadow stacks and returns its result word
    function automatic t_out_word apply_stack_op(t_in_word w);
        t_out_word         r;
        logic [LINK_W-1:0] slot;
        r.status    = STS_DONE;
        r.pop_value = '0;
        if (w.mode == MODE_PUSH) begin
            if (int'(w.stack_sel) >= NUM_STACKS || free_first >= NIL) begin
                r.status = STS_FULL;
            end else begin
                slot       = free_first;
                free_first = entry_next[slot[IDX_W-1:0]];
                if (free_first > NIL) begin
                    free_first = NIL;
                end
                entry_word[slot[IDX_W-1:0]] = w.push_value;
                entry_next[slot[IDX_W-1:0]] = stack_top[w.stack_sel];
                stack_top[w.stack_sel]      = slot;
            end
        end else begin
            if (int'(w.stack_sel) >= NUM_STACKS || stack_top[w.stack_sel] >= NIL) begin
                r.status = STS_EMPTY;
            end else begin
                slot                   = stack_top[w.stack_sel];
                stack_top[w.stack_sel] = entry_next[slot[IDX_W-1:0]];
                if (stack_top[w.stack_sel] > NIL) begin
                    stack_top[w.stack_sel] = NIL;
                end
                entry_next[slot[IDX_W-1:0]] = free_first;
                free_first                  = slot;
                r.pop_value                 = entry_word[slot[IDX_W-1:0]];
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_word want;
        if (!i_rst_n) begin
            clear_stacks();
            pending_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result word with none expected: status %0d, pop_value %0d",
                           i_out_data.status, i_out_data.pop_value);
                    mismatch_total++;
                end else begin
                    want = pending_results.pop_front();
                    if (i_out_data.status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, i_out_data.status);
                        mismatch_total++;
                    end
                    if (i_out_data.pop_value !== want.pop_value) begin
                        $error("pop_value mismatch: expected %0d, actual %0d",
                               want.pop_value, i_out_data.pop_value);
                        mismatch_total++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                pending_results.push_back(apply_stack_op(i_in_data));
            end
        end
        pending_total = pending_results.size();
    end

endmodule

FILE: tb/tb_top.sv
// top of the multi stack shared buffer testbench: clock, reset, stimulus
// and verdict; depends on mssb_pkg, mssb_checker and the block itself
module tb_top;
    import mssb_pkg::*;

    localparam int HOLD_CYCLES = 150;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_word  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_word o_out_data;

    int error_count;
    int pending_count;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_req;

    multi_stack_shared_buffer_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    mssb_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_in_data       (i_in_data),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_out_data      (o_out_data),
        .o_error_count   (error_count),
        .o_pending_count (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver side: random stall, or one long hold-off on request
    initial begin : receiver
        bit hold_taken;
        hold_taken  = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_taken) begin
                hold_taken  = 1'b1;
                i_out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_out_stall = ($urandom_range(99) < recv_idle_pct);
        end
    end

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(7))
            0: begin
                case ($urandom_range(3))
                    0: return 32'sh7fff_ffff;
                    1: return 32'sh8000_0000;
                    2: return -32'sd1;
                    default: return '0;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_word make_word(logic mode, int sel, logic signed [DATA_W-1:0] v);
        t_in_word w;
        w.mode       = mode;
        w.stack_sel  = SEL_W'(sel);
        w.push_value = v;
        return w;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(input t_in_word w);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_data  = w;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic push_word(int sel, logic signed [DATA_W-1:0] v);
        send_word(make_word(MODE_PUSH, sel, v));
    endtask

    task automatic pop_word(int sel);
        // value field is don't care on a pop, keep it random anyway
        send_word(make_word(MODE_POP, sel, $urandom));
    endtask

    task automatic run_burst(int push_pct, int len);
        logic mode;
        for (int n = 0; n < len; n++) begin
            mode = ($urandom_range(99) < push_pct) ? MODE_PUSH : MODE_POP;
            send_word(make_word(mode, $urandom_range((1 << SEL_W) - 1), pick_value()));
        end
    endtask

    task automatic drain_and_set(int snd_pct, int rcv_pct);
        i_in_valid = 1'b0;
        wait (pending_count == 0);
        @(negedge i_clk);
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
    endtask

    // fill until full, then a run of pops on random stacks, then mixed bursts
    task automatic random_phase();
        int done_items;
        int bias;
        int len;
        run_burst(100, 66);
        run_burst(0, 66);
        done_items = 0;
        while (done_items < 55) begin
            case ($urandom_range(2))
                0: bias = 90;
                1: bias = 50;
                default: bias = 10;
            endcase
            len = $urandom_range(40, 10);
            run_burst(bias, len);
            done_items += len;
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        hold_req      = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // every stack starts empty
        for (int s = 0; s < NUM_STACKS; s++) begin
            pop_word(s);
        end
        push_word(0, 32'sh7fff_ffff);
        push_word(1, 32'sh8000_0000);
        push_word(2, -32'sd1);
        push_word(3, 32'sh0000_0000);
        push_word(0, 32'sh5555_aaaa);
        push_word(1, 32'shaaaa_5555);
        pop_word(3);
        // a stored all-ones word must come back as data, not as empty
        pop_word(2);
        pop_word(1);
        pop_word(1);
        pop_word(0);
        pop_word(0);
        pop_word(0);
        pop_word(2);
        push_word(3, 32'sh1234_5678);
        pop_word(3);
        pop_word(3);

        drain_and_set(25, 68);
        random_phase();
        drain_and_set(68, 25);
        random_phase();
        drain_and_set(0, 0);
        // long receiver hold-off while words keep coming
        hold_req = 1'b1;
        run_burst(60, 24);
        random_phase();

        i_in_valid = 1'b0;
        wait (pending_count == 0);
        repeat (8) @(posedge i_clk);
        if (error_count == 0 && pending_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
